// ----- design/utf8sd_pkg.sv -----
// utf8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package utf8sd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int DUE_W    = 2;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [CP_W-1:0]     cp_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [DUE_W-1:0]    due_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_LEAD  = 2'd1;
    localparam status_t STATUS_TRUNCATED = 2'd2;

    // Lead byte boundaries
    localparam byte_t ASCII_LIMIT = 8'h80;
    localparam byte_t CONT_LAST   = 8'hBF;
    localparam byte_t LEAD2_FIRST = 8'hC0;
    localparam byte_t LEAD3_FIRST = 8'hE0;
    localparam byte_t LEAD4_FIRST = 8'hF0;
    localparam byte_t BAD_FIRST   = 8'hF8;

    // One input item as held in the input register
    typedef struct packed {
        byte_t data_byte;
        logic  end_of_text;
    } in_item_t;

    // One decode outcome handed to the output register
    typedef struct packed {
        logic    emit;
        cp_t     code_point;
        status_t status;
    } result_t;

endpackage

`default_nettype wire

// ----- design/utf8sd_in_reg.sv -----
// utf8sd_in_reg: input pipeline register for the byte stream.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_in_reg
    import utf8sd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          held_valid,
    input  wire logic     held_take,
    output in_item_t      held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Refill in the same cycle the held byte moves on
    assign in_ready   = !valid_reg || held_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !held_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ----- design/utf8sd_decode.sv -----
// utf8sd_decode: sequence state and the per-byte decode step.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_decode
    import utf8sd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_item_t item,
    output result_t       res
);

    due_t  bytes_due_reg;
    due_t  bytes_due_next;
    cp_t   partial_value_reg;
    cp_t   partial_value_next;
    byte_t b;

    assign b = item.data_byte;

    always_comb
    begin
        bytes_due_next     = bytes_due_reg;
        partial_value_next = partial_value_reg;
        res.emit           = 1'b0;
        res.code_point     = '0;
        res.status         = STATUS_OK;

        if (bytes_due_reg != '0)
        begin
            // Continuation: top bits ignored
            partial_value_next = {partial_value_reg[CP_W-7:0], b[5:0]};
            bytes_due_next     = bytes_due_reg - due_t'(1);
        end
        else if (b < ASCII_LIMIT)
        begin
            // nothing to hold
        end
        else if (b inside {[ASCII_LIMIT:CONT_LAST], [BAD_FIRST:8'hFF]})
        begin
            partial_value_next = '0;
        end
        else if (b < LEAD3_FIRST)
        begin
            partial_value_next = cp_t'(b[4:0]);
            bytes_due_next     = due_t'(1);
        end
        else if (b < LEAD4_FIRST)
        begin
            partial_value_next = cp_t'(b[3:0]);
            bytes_due_next     = due_t'(2);
        end
        else
        begin
            partial_value_next = cp_t'(b[2:0]);
            bytes_due_next     = due_t'(3);
        end

        if (bytes_due_reg != '0 && bytes_due_next == '0)
        begin
            res.emit           = 1'b1;
            res.code_point     = partial_value_next;
            partial_value_next = '0;
        end
        else if (bytes_due_reg == '0 && b < ASCII_LIMIT)
        begin
            res.emit       = 1'b1;
            res.code_point = cp_t'(b);
        end
        else if (bytes_due_reg == '0 && b < LEAD2_FIRST)
        begin
            res.emit   = 1'b1;
            res.status = STATUS_BAD_LEAD;
        end
        else if (bytes_due_reg == '0 && b >= BAD_FIRST)
        begin
            res.emit   = 1'b1;
            res.status = STATUS_BAD_LEAD;
        end
        else if (item.end_of_text)
        begin
            // Sequence still open at end of text
            res.emit           = 1'b1;
            res.status         = STATUS_TRUNCATED;
            bytes_due_next     = '0;
            partial_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_due_reg     <= '0;
            partial_value_reg <= '0;
        end
        else if (fire)
        begin
            bytes_due_reg     <= bytes_due_next;
            partial_value_reg <= partial_value_next;
        end
    end

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_due_reg == '0 |-> partial_value_reg == '0)
        else $error("partial value left over with no sequence open");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.emit && res.status != STATUS_OK |-> res.code_point == '0)
        else $error("non-zero code point on error status");

    a_eot_close: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_text |=> bytes_due_reg == '0)
        else $error("sequence still open after end of text");

    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        fire && bytes_due_reg == '0 && b < ASCII_LIMIT
        |-> res.emit && res.status == STATUS_OK)
        else $error("ASCII byte did not give a code point");

endmodule

`default_nettype wire

// ----- design/utf8sd_out_reg.sv -----
// utf8sd_out_reg: result register between the decode step and the receiver.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_out_reg
    import utf8sd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res,
    output logic         space,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cp_t          code_point,
    output status_t      status
);

    logic    valid_reg;
    logic    valid_next;
    cp_t     code_point_reg;
    status_t status_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = (load && res.emit) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.emit)
        begin
            code_point_reg <= res.code_point;
            status_reg     <= res.status;
        end
    end

    assign out_valid  = valid_reg;
    assign code_point = code_point_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ----- design/utf8_stream_decoder_unit.sv -----
// utf8_stream_decoder_unit: top level of the UTF-8 stream decoder.
// Depends on utf8sd_pkg, utf8sd_in_reg, utf8sd_decode, utf8sd_out_reg.
//
// Input channel (in_valid/in_ready): one byte of UTF-8 text per transfer,
// with end_of_text set on the last byte of a text.
// Output channel (out_valid/out_ready): one code point and status per
// transfer. A byte gives at most one result: ASCII, the last byte of a
// sequence, a bad lead byte, or a sequence cut short by end_of_text.
// Each byte is held in the input register, decoded from there into the
// result register, and its result is offered from the result register.
// Throughput: one byte per cycle while out_ready is high; the decode step is
// a six-bit shift and a two-bit count between the input and result registers.
// Reset clears the sequence state and empties both registers.
// When the receiver stalls, the result register holds and the byte in the
// input register waits behind it; at most two bytes are held, and in_ready
// stays low until the waiting result is transferred.
`default_nettype none

module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                end_of_text,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CP_W-1:0]          code_point,
    output logic [STATUS_W-1:0]      status
);

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     space;
    logic     fire;
    result_t  res;

    assign in_item.data_byte   = data_byte;
    assign in_item.end_of_text = end_of_text;
    assign fire                = held_valid && space;

    utf8sd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_take  (fire),
        .held_item  (held_item)
    );

    utf8sd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (held_item),
        .res   (res)
    );

    utf8sd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .res        (res),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .status     (status)
    );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for utf8_stream_decoder_unit.
// Depends on utf8sd_pkg and the decoder RTL; a local decoder model predicts
// each result, and directed and random byte streams run with random idling.

module tb_top
    import utf8sd_pkg::*;
();

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 500;
    localparam int IDLE_PCT       = 16;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        cp_t     code_point;
        status_t status;
    } decoded_t;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    in_valid    = 1'b0;
    byte_t   data_byte   = '0;
    logic    end_of_text = 1'b0;
    logic    out_ready   = 1'b0;
    wire     in_ready;
    wire     out_valid;
    wire     [CP_W-1:0]     code_point;
    wire     [STATUS_W-1:0] status;

    // decoder model state
    due_t     seq_due   = '0;
    cp_t      seq_value = '0;
    decoded_t decoded_q[$];

    logic no_idle     = 1'b0;
    int   hold_reqs   = 0;
    int   hold_served = 0;
    int   hold_left   = 0;
    int   cycle_count = 0;
    int   err_count   = 0;
    int   n_sent      = 0;
    int   n_checked   = 0;
    int   n_bad_lead  = 0;
    int   n_truncated = 0;

    utf8_stream_decoder_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_decoded(input cp_t cp, input status_t st);
        decoded_t d;
        d.code_point = cp;
        d.status     = st;
        decoded_q.push_back(d);
    endtask

    // Decode one transferred byte and queue what the block must produce
    task automatic decode_byte(input byte_t b, input logic eot);
        logic emitted;
        emitted = 1'b0;
        if (seq_due != 0)
        begin
            // every byte counts as a continuation here, top bits ignored
            seq_value = {seq_value[CP_W-7:0], b[5:0]};
            seq_due   = seq_due - 1'b1;
            if (seq_due == 0)
            begin
                push_decoded(seq_value, STATUS_OK);
                seq_value = '0;
                emitted   = 1'b1;
            end
        end
        else if (b < ASCII_LIMIT)
        begin
            push_decoded({{(CP_W-BYTE_W){1'b0}}, b}, STATUS_OK);
            emitted = 1'b1;
        end
        else if (b < LEAD2_FIRST || b >= BAD_FIRST)
        begin
            seq_value = '0;
            push_decoded('0, STATUS_BAD_LEAD);
            emitted = 1'b1;
        end
        else if (b < LEAD3_FIRST)
        begin
            seq_value = {{(CP_W-5){1'b0}}, b[4:0]};
            seq_due   = 2'd1;
        end
        else if (b < LEAD4_FIRST)
        begin
            seq_value = {{(CP_W-4){1'b0}}, b[3:0]};
            seq_due   = 2'd2;
        end
        else
        begin
            seq_value = {{(CP_W-3){1'b0}}, b[2:0]};
            seq_due   = 2'd3;
        end

        // open sequence cut off by the end mark
        if (!emitted && eot)
        begin
            seq_due   = '0;
            seq_value = '0;
            push_decoded('0, STATUS_TRUNCATED);
        end
    endtask

    task automatic send_byte(input byte_t b, input logic eot);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent = n_sent + 1;
        decode_byte(b, eot);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_reqs)
        begin
            hold_served <= hold_reqs;
            hold_left   <= HOLDOFF_CYCLES;
            out_ready   <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: code_point %h status %0d", code_point, status);
                err_count = err_count + 1;
            end
            else
            begin
                want = decoded_q.pop_front();
                n_checked <= n_checked + 1;
                if (want.status == STATUS_BAD_LEAD)
                    n_bad_lead <= n_bad_lead + 1;
                if (want.status == STATUS_TRUNCATED)
                    n_truncated <= n_truncated + 1;
                if (code_point !== want.code_point)
                begin
                    $error("code_point: expected %h, got %h", want.code_point, code_point);
                    err_count = err_count + 1;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_count = err_count + 1;
                end
            end
        end
    end

    function automatic byte_t lead_byte(input int len);
        case (len)
            1:       return byte_t'($urandom_range(ASCII_LIMIT - 1, 0));
            2:       return byte_t'($urandom_range(LEAD3_FIRST - 1, LEAD2_FIRST));
            3:       return byte_t'($urandom_range(LEAD4_FIRST - 1, LEAD3_FIRST));
            default: return byte_t'($urandom_range(BAD_FIRST - 1, LEAD4_FIRST));
        endcase
    endfunction

    // mostly proper continuation bytes, now and then any byte at all
    function automatic byte_t cont_byte();
        if ($urandom_range(7) == 0)
            return byte_t'($urandom_range(255, 0));
        return byte_t'(8'h80 | ($urandom & 8'h3F));
    endfunction

    task automatic test_ascii_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_stray_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // bad lead on the last byte gives only the bad-lead status
        send_byte(8'hF8, 1'b1);
    endtask

    task automatic test_sequences();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // end mark on the completing byte still decodes normally
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
    endtask

    task automatic test_lead_inside_sequence();
        send_byte(8'hE2, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hC1, 1'b0);
    endtask

    task automatic test_truncated();
        send_byte(8'hC2, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    task automatic test_receiver_holdoff();
        int k;
        no_idle   <= 1'b1;
        hold_reqs <= hold_reqs + 1;
        for (k = 0; k < 40; k++)
            send_byte(byte_t'($urandom_range(ASCII_LIMIT - 1, 0)), 1'b0);
    endtask

    task automatic test_random_stream();
        int    first;
        int    kind;
        int    len;
        int    cut;
        int    k;
        first = n_sent;
        while (n_sent - first < RANDOM_ITEMS)
        begin
            // one stretch with no idling on either side
            no_idle <= (n_sent - first >= 200) && (n_sent - first < 300);
            kind = $urandom_range(99);
            if (kind < 15)
                send_byte(byte_t'($urandom_range(255, 0)), $urandom_range(7) == 0);
            else if (kind < 25)
            begin
                len = $urandom_range(4, 2);
                cut = $urandom_range(len - 2, 0);
                send_byte(lead_byte(len), cut == 0);
                for (k = 1; k <= cut; k++)
                    send_byte(cont_byte(), k == cut);
            end
            else
            begin
                len = $urandom_range(4, 1);
                send_byte(lead_byte(len), (len == 1) && ($urandom_range(9) == 0));
                for (k = 1; k < len; k++)
                    send_byte(cont_byte(), (k == len - 1) && ($urandom_range(9) == 0));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_extremes();
        test_stray_leads();
        test_sequences();
        test_lead_inside_sequence();
        test_truncated();
        test_receiver_holdoff();
        test_random_stream();

        in_valid <= 1'b0;
        no_idle  <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes; checked %0d results (%0d bad lead, %0d truncated).",
                 n_sent, n_checked, n_bad_lead, n_truncated);
        $display("Covered ASCII, 2-4 byte sequences, stray leads, cut-offs and a long stall.");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
